/* src/tbse_pkg.sv */
// Shared constants, types and helper functions of the two-bank set engine.
package tbse_pkg;

   // Slots per set and compared element width
   localparam int SET_CAPACITY = 16;
   localparam int ELEMENT_BITS = 32;

   // Widths of the external fields
   localparam int KIND_BITS   = 3;
   localparam int MEMBER_BITS = 32;
   localparam int WIDE_BITS   = 64;

   // Slot index and slot counter widths
   localparam int SLOT_BITS  = (SET_CAPACITY > 1) ? $clog2(SET_CAPACITY) : 1;
   localparam int COUNT_BITS = $clog2(SET_CAPACITY + 1);

   // Transaction kinds
   localparam logic [KIND_BITS-1:0] KIND_INSERT    = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_REMOVE    = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_LOOKUP    = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_UNION     = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_DIFF      = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_INTERSECT = 3'd5;

   typedef logic [ELEMENT_BITS-1:0] elem_type;
   typedef logic [SLOT_BITS-1:0]    slot_type;

   // Slot store access from the sequencer
   typedef struct packed {
      logic     rd_en;
      logic     rd_bank;
      slot_type rd_slot;
      logic     wr_en;
      logic     clr_en;
      logic     wr_bank;
      slot_type wr_slot;
      elem_type wr_data;
   } store_cmd_type;

   // Result transaction handed to the output register
   typedef struct packed {
      logic                   vld;
      logic [MEMBER_BITS-1:0] member;
      logic                   present;
      logic                   refused;
      logic                   empty_res;
      logic                   last;
   } emit_type;

   // Sign-extend the 32-bit input and keep the compared width
   function automatic elem_type key_of(input logic [MEMBER_BITS-1:0] element);
      logic [WIDE_BITS-1:0] wide;
      wide = {{(WIDE_BITS - MEMBER_BITS){element[MEMBER_BITS-1]}}, element};
      return wide[ELEMENT_BITS-1:0];
   endfunction

   // Zero-extend a stored element and keep the low 32 bits
   function automatic logic [MEMBER_BITS-1:0] member_of(input elem_type key);
      logic [WIDE_BITS-1:0] wide;
      wide = WIDE_BITS'(key);
      return wide[MEMBER_BITS-1:0];
   endfunction

endpackage

/* src/tbse_if.sv */
// Request and response channel interfaces of the two-bank set engine.
interface tbse_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [tbse_pkg::KIND_BITS-1:0]       kind;
   logic                                 bank;
   logic signed [tbse_pkg::MEMBER_BITS-1:0] element;

   modport source (output valid, output kind, output bank, output element, input ready);
   modport sink   (input valid, input kind, input bank, input element, output ready);
endinterface

interface tbse_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [tbse_pkg::MEMBER_BITS-1:0] member;
   logic                                 present;
   logic                                 refused;
   logic                                 empty_res;
   logic                                 last;

   modport source (output valid, output member, output present, output refused,
                   output empty_res, output last, input ready);
   modport sink   (input valid, input member, input present, input refused,
                   input empty_res, input last, output ready);
endinterface

/* src/two_bank_set_engine.sv */
// Top level of the two-bank set engine: channels, output register, sequencer and store.
//
//   channel   dir   handshake          payload
//   req_ch    in    valid / ready      kind, bank, element
//   rsp_ch    out   valid / ready      member, present, refused, empty_res, last
//
// Insert, remove and lookup read every slot of the addressed set and then answer:
// one shared comparator walks the set one slot per cycle through the registered memory port.
// Difference and intersection probe the other set once for each occupied slot of the left set;
// union first streams the left set, then adds each right-set element missing from the left.
// Reset is synchronous and empties both sets at once; no clearing pass is needed.
// A stalled response channel holds the sequencer at its next result; a new
// transaction is taken only when the previous one has issued all its results.
module two_bank_set_engine (
   input  logic       clock,
   input  logic       reset,
   tbse_req_if.sink   req_ch,
   tbse_rsp_if.source rsp_ch
);

   tbse_pkg::store_cmd_type                 store_cmd;
   tbse_pkg::emit_type                      emit;
   tbse_pkg::elem_type                      rd_data;
   logic [1:0][tbse_pkg::SET_CAPACITY-1:0]  slot_valid;
   logic                                    seq_idle;
   logic                                    req_accept;
   logic                                    out_free;

   logic                                    rsp_vld_ff;
   logic [tbse_pkg::MEMBER_BITS-1:0]        rsp_member_ff;
   logic                                    rsp_present_ff;
   logic                                    rsp_refused_ff;
   logic                                    rsp_empty_ff;
   logic                                    rsp_last_ff;

   assign req_ch.ready = seq_idle;
   assign req_accept   = req_ch.valid && seq_idle;
   assign out_free     = !rsp_vld_ff || rsp_ch.ready;

   tbse_sequencer u_sequencer (
      .clock         (clock),
      .reset         (reset),
      .req_accept_i  (req_accept),
      .req_kind_i    (req_ch.kind),
      .req_bank_i    (req_ch.bank),
      .req_element_i (req_ch.element),
      .idle_o        (seq_idle),
      .out_free_i    (out_free),
      .emit_o        (emit),
      .cmd_o         (store_cmd),
      .rd_data_i     (rd_data),
      .valid_i       (slot_valid)
   );

   tbse_slot_store u_slot_store (
      .clock     (clock),
      .reset     (reset),
      .cmd_i     (store_cmd),
      .rd_data_o (rd_data),
      .valid_o   (slot_valid)
   );

   // Load the output register, drop it once the transaction is taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (emit.vld) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_vld_ff <= 1'b0;
      end
      if (emit.vld) begin
         rsp_member_ff  <= emit.member;
         rsp_present_ff <= emit.present;
         rsp_refused_ff <= emit.refused;
         rsp_empty_ff   <= emit.empty_res;
         rsp_last_ff    <= emit.last;
      end
   end

   assign rsp_ch.valid     = rsp_vld_ff;
   assign rsp_ch.member    = rsp_member_ff;
   assign rsp_ch.present   = rsp_present_ff;
   assign rsp_ch.refused   = rsp_refused_ff;
   assign rsp_ch.empty_res = rsp_empty_ff;
   assign rsp_ch.last      = rsp_last_ff;

endmodule

/* src/tbse_slot_store.sv */
// Slot value memory and slot valid bits of both sets.
module tbse_slot_store (
   input  logic                                            clock,
   input  logic                                            reset,
   input  tbse_pkg::store_cmd_type                         cmd_i,
   output tbse_pkg::elem_type                              rd_data_o,
   output logic [1:0][tbse_pkg::SET_CAPACITY-1:0]          valid_o
);

   tbse_pkg::elem_type                     slot_mem_ff [2][tbse_pkg::SET_CAPACITY];
   tbse_pkg::elem_type                     rd_data_ff;
   logic [1:0][tbse_pkg::SET_CAPACITY-1:0] valid_ff;

   // Write and read the value memory, read data registered
   always_ff @(posedge clock) begin
      if (cmd_i.wr_en) begin
         slot_mem_ff[cmd_i.wr_bank][cmd_i.wr_slot] <= cmd_i.wr_data;
      end
      if (cmd_i.rd_en) begin
         rd_data_ff <= slot_mem_ff[cmd_i.rd_bank][cmd_i.rd_slot];
      end
   end

   // Set valid on write, drop valid on remove
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd_i.wr_en) begin
         valid_ff[cmd_i.wr_bank][cmd_i.wr_slot] <= 1'b1;
      end else if (cmd_i.clr_en) begin
         valid_ff[cmd_i.wr_bank][cmd_i.wr_slot] <= 1'b0;
      end
   end

   assign rd_data_o = rd_data_ff;
   assign valid_o   = valid_ff;

endmodule

/* src/tbse_sequencer.sv */
// Sequencer that drives the shared slot comparator over both sets.
module tbse_sequencer (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_accept_i,
   input  logic [tbse_pkg::KIND_BITS-1:0]           req_kind_i,
   input  logic                                     req_bank_i,
   input  logic [tbse_pkg::MEMBER_BITS-1:0]         req_element_i,
   output logic                                     idle_o,
   input  logic                                     out_free_i,
   output tbse_pkg::emit_type                       emit_o,
   output tbse_pkg::store_cmd_type                  cmd_o,
   input  tbse_pkg::elem_type                       rd_data_i,
   input  logic [1:0][tbse_pkg::SET_CAPACITY-1:0]   valid_i
);

   typedef enum logic [2:0] {
      ST_IDLE, ST_OUTER, ST_LOAD, ST_PROBE, ST_DECIDE, ST_EMIT, ST_FINISH, ST_POINT
   } state_type;

   localparam logic [tbse_pkg::COUNT_BITS-1:0] CNT_END =
      tbse_pkg::COUNT_BITS'(tbse_pkg::SET_CAPACITY);
   localparam logic [tbse_pkg::COUNT_BITS-1:0] CNT_ONE = tbse_pkg::COUNT_BITS'(1);

   state_type                            state_ff, state_in;
   logic [tbse_pkg::KIND_BITS-1:0]       kind_ff, kind_in;
   logic                                 left_ff, left_in;
   logic                                 phase_b_ff, phase_b_in;
   logic [tbse_pkg::MEMBER_BITS-1:0]     echo_ff, echo_in;
   tbse_pkg::elem_type                   key_ff, key_in;
   logic [tbse_pkg::COUNT_BITS-1:0]      oi_ff, oi_in;
   logic [tbse_pkg::COUNT_BITS-1:0]      pi_ff, pi_in;
   logic                                 found_ff, found_in;
   tbse_pkg::slot_type                   found_idx_ff, found_idx_in;
   logic                                 free_ff, free_in;
   tbse_pkg::slot_type                   free_idx_ff, free_idx_in;
   logic                                 pend_vld_ff, pend_vld_in;
   tbse_pkg::elem_type                   pend_ff, pend_in;

   logic                                 set_op;
   logic                                 outer_bank;
   logic                                 probe_bank;
   logic [tbse_pkg::COUNT_BITS-1:0]      cmp_cnt;
   tbse_pkg::slot_type                   cmp_idx;
   logic                                 slot_hit;
   logic                                 qualify;

   // Operand banks and the shared comparator
   always_comb begin
      set_op     = kind_ff inside {tbse_pkg::KIND_UNION, tbse_pkg::KIND_DIFF,
                                   tbse_pkg::KIND_INTERSECT};
      outer_bank = left_ff ^ phase_b_ff;
      probe_bank = set_op ? ~outer_bank : left_ff;
      cmp_cnt    = pi_ff - CNT_ONE;
      cmp_idx    = cmp_cnt[tbse_pkg::SLOT_BITS-1:0];
      slot_hit   = valid_i[probe_bank][cmp_idx] && (rd_data_i == key_ff);
      qualify    = ((kind_ff == tbse_pkg::KIND_DIFF) && !found_ff) ||
                   ((kind_ff == tbse_pkg::KIND_INTERSECT) && found_ff) ||
                   (phase_b_ff && !found_ff);
   end

   // Next state, store commands and result transactions
   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      left_in      = left_ff;
      phase_b_in   = phase_b_ff;
      echo_in      = echo_ff;
      key_in       = key_ff;
      oi_in        = oi_ff;
      pi_in        = pi_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      pend_vld_in  = pend_vld_ff;
      pend_in      = pend_ff;
      cmd_o        = '0;
      emit_o       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept_i) begin
               kind_in     = req_kind_i;
               left_in     = req_bank_i;
               echo_in     = req_element_i;
               key_in      = tbse_pkg::key_of(req_element_i);
               phase_b_in  = 1'b0;
               oi_in       = '0;
               pi_in       = '0;
               found_in    = 1'b0;
               free_in     = 1'b0;
               pend_vld_in = 1'b0;
               case (req_kind_i)
                  tbse_pkg::KIND_INSERT, tbse_pkg::KIND_REMOVE,
                  tbse_pkg::KIND_LOOKUP: state_in = ST_PROBE;
                  tbse_pkg::KIND_UNION, tbse_pkg::KIND_DIFF,
                  tbse_pkg::KIND_INTERSECT: state_in = ST_OUTER;
                  default: state_in = ST_POINT;
               endcase
            end
         end

         // Walk the outer set, skip empty slots
         ST_OUTER: begin
            if (oi_ff == CNT_END) begin
               if ((kind_ff == tbse_pkg::KIND_UNION) && !phase_b_ff) begin
                  phase_b_in = 1'b1;
                  oi_in      = '0;
               end else begin
                  state_in = ST_FINISH;
               end
            end else if (valid_i[outer_bank][oi_ff[tbse_pkg::SLOT_BITS-1:0]]) begin
               cmd_o.rd_en   = 1'b1;
               cmd_o.rd_bank = outer_bank;
               cmd_o.rd_slot = oi_ff[tbse_pkg::SLOT_BITS-1:0];
               state_in      = ST_LOAD;
            end else begin
               oi_in = oi_ff + CNT_ONE;
            end
         end

         // Take the outer element as the probe key
         ST_LOAD: begin
            key_in = rd_data_i;
            if ((kind_ff == tbse_pkg::KIND_UNION) && !phase_b_ff) begin
               state_in = ST_EMIT;
            end else begin
               pi_in    = '0;
               found_in = 1'b0;
               state_in = ST_PROBE;
            end
         end

         // Read one slot per cycle, compare the one read last cycle
         ST_PROBE: begin
            if (pi_ff != CNT_END) begin
               cmd_o.rd_en   = 1'b1;
               cmd_o.rd_bank = probe_bank;
               cmd_o.rd_slot = pi_ff[tbse_pkg::SLOT_BITS-1:0];
            end
            if (pi_ff != '0) begin
               if (slot_hit && !found_ff) begin
                  found_in     = 1'b1;
                  found_idx_in = cmp_idx;
               end
               if (!valid_i[probe_bank][cmp_idx] && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = cmp_idx;
               end
            end
            if (pi_ff == CNT_END) begin
               state_in = set_op ? ST_DECIDE : ST_POINT;
            end else begin
               pi_in = pi_ff + CNT_ONE;
            end
         end

         ST_DECIDE: begin
            if (qualify) begin
               state_in = ST_EMIT;
            end else begin
               oi_in    = oi_ff + CNT_ONE;
               state_in = ST_OUTER;
            end
         end

         // Release the held element, hold the new one until the next is known
         ST_EMIT: begin
            if (!pend_vld_ff || out_free_i) begin
               if (pend_vld_ff) begin
                  emit_o.vld    = 1'b1;
                  emit_o.member = tbse_pkg::member_of(pend_ff);
               end
               pend_vld_in = 1'b1;
               pend_in     = key_ff;
               oi_in       = oi_ff + CNT_ONE;
               state_in    = ST_OUTER;
            end
         end

         ST_FINISH: begin
            if (out_free_i) begin
               emit_o.vld       = 1'b1;
               emit_o.last      = 1'b1;
               emit_o.member    = pend_vld_ff ? tbse_pkg::member_of(pend_ff) : '0;
               emit_o.empty_res = !pend_vld_ff;
               state_in         = ST_IDLE;
            end
         end

         // Answer insert, remove, lookup and unknown kinds; update the set
         ST_POINT: begin
            if (out_free_i) begin
               emit_o.vld     = 1'b1;
               emit_o.last    = 1'b1;
               emit_o.member  = echo_ff;
               emit_o.present = found_ff;
               emit_o.refused = (kind_ff == tbse_pkg::KIND_INSERT) && !found_ff && !free_ff;
               cmd_o.wr_bank  = left_ff;
               cmd_o.wr_data  = key_ff;
               if ((kind_ff == tbse_pkg::KIND_INSERT) && !found_ff && free_ff) begin
                  cmd_o.wr_en   = 1'b1;
                  cmd_o.wr_slot = free_idx_ff;
               end else if ((kind_ff == tbse_pkg::KIND_REMOVE) && found_ff) begin
                  cmd_o.clr_en  = 1'b1;
                  cmd_o.wr_slot = found_idx_ff;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // Hold sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         pend_vld_ff <= 1'b0;
         found_ff    <= 1'b0;
         free_ff     <= 1'b0;
         phase_b_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         pend_vld_ff <= pend_vld_in;
         found_ff    <= found_in;
         free_ff     <= free_in;
         phase_b_ff  <= phase_b_in;
      end
      kind_ff      <= kind_in;
      left_ff      <= left_in;
      echo_ff      <= echo_in;
      key_ff       <= key_in;
      oi_ff        <= oi_in;
      pi_ff        <= pi_in;
      found_idx_ff <= found_idx_in;
      free_idx_ff  <= free_idx_in;
      pend_ff      <= pend_in;
   end

   assign idle_o = (state_ff == ST_IDLE);

   // A result goes out only when the output register can take it
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit_o.vld |-> out_free_i)
      else $error("result issued while output register busy");

   // Insert fills only a free slot
   a_write_free: assert property (@(posedge clock) disable iff (reset)
      cmd_o.wr_en |-> !valid_i[cmd_o.wr_bank][cmd_o.wr_slot])
      else $error("insert overwrote an occupied slot");

   // Remove drops only an occupied slot
   a_clear_used: assert property (@(posedge clock) disable iff (reset)
      cmd_o.clr_en |-> valid_i[cmd_o.wr_bank][cmd_o.wr_slot])
      else $error("remove cleared an empty slot");

   // The closing result returns the sequencer to idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      emit_o.vld && emit_o.last |=> state_ff == ST_IDLE)
      else $error("sequencer busy after final result");

   // A refused insert never reports a present element
   a_refused_new: assert property (@(posedge clock) disable iff (reset)
      emit_o.vld && emit_o.refused |-> !emit_o.present && !emit_o.empty_res)
      else $error("refusal flagged on a present element");

endmodule
